/* rtl/gbn_pkg.sv */
// Shared types, constants and helpers for the go-back-N sender window.
// No dependencies; every other file in rtl/ imports this package.
package gbn_pkg;

  // Sequence space and transfer limits
  localparam int unsigned SeqSpace   = 20;
  localparam int unsigned MaxPackets = 128;
  localparam int unsigned SeqW       = 5;   // holds 0..SeqSpace
  localparam int unsigned CntW       = 8;   // holds 0..MaxPackets
  localparam int unsigned IdxW       = 7;   // packet index field
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;
  localparam int unsigned AckW       = 8;
  localparam int unsigned ReqW       = 2;
  localparam int unsigned TdataInW   = 8;
  localparam int unsigned TdataOutW  = 32;

  // Command queue between front and back
  localparam int unsigned FifoDepth  = 2;
  localparam int unsigned FifoPtrW   = 1;
  localparam int unsigned FifoCntW   = 2;

  localparam logic [SeqW-1:0] SeqLast  = SeqW'(SeqSpace - 1);
  localparam logic [SeqW-1:0] SeqTop   = SeqW'(SeqSpace);
  localparam logic [CntW-1:0] PktLimit = CntW'(MaxPackets);

  // Request codes on the input channel
  localparam logic [ReqW-1:0] ReqStart = 2'd0;
  localparam logic [ReqW-1:0] ReqSend  = 2'd1;
  localparam logic [ReqW-1:0] ReqAck   = 2'd2;
  localparam logic [ReqW-1:0] ReqPoll  = 2'd3;

  // Register indexes on the config port
  localparam logic [CfgIdxW-1:0] CfgWindow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTotal   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeout = 2'd2;

  // Reset values of the config registers
  localparam logic [SeqW-1:0]     WindowRst  = 5'd10;
  localparam logic [CntW-1:0]     TotalRst   = 8'd0;
  localparam logic [CfgDataW-1:0] TimeoutRst = 8'd20;

  // Classified command kinds
  typedef enum logic [2:0] {
    CmdStart,
    CmdSend,
    CmdDone,
    CmdAckBad,
    CmdAckOk,
    CmdPoll
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e       kind;
    logic [SeqW-1:0] ack_idx;   // acknowledged sequence, valid for CmdAckOk
  } cmd_t;

  typedef struct packed {
    logic [SeqW-1:0]     window_size;
    logic [CntW-1:0]     total_packets;
    logic [CfgDataW-1:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic            sent;
    logic [SeqW-1:0] seq_code;
    logic [IdxW-1:0] packet_index;
    logic            last_packet;
    logic            timed_out;
    logic [SeqW-1:0] rewound;
    logic            ack_rejected;
    logic            transfer_done;
    logic [SeqW-1:0] outstanding;
  } result_t;

  // Distance from b forward to a, modulo the sequence space (a, b < SeqSpace)
  function automatic logic [SeqW-1:0] seq_dist(input logic [SeqW-1:0] a,
                                               input logic [SeqW-1:0] b);
    logic [SeqW-1:0] d;
    if (a >= b) begin
      d = a - b;
    end else begin
      d = a + (SeqTop - b);
    end
    return d;
  endfunction

  // Next sequence number with wrap
  function automatic logic [SeqW-1:0] seq_inc(input logic [SeqW-1:0] a);
    logic [SeqW-1:0] n;
    if (a == SeqLast) begin
      n = '0;
    end else begin
      n = a + 5'd1;
    end
    return n;
  endfunction

endpackage

/* rtl/go_back_n_sender_window_top.sv */
// Top level of the go-back-N sender window: config registers, front end,
// command queue, back end. Depends on gbn_pkg, gbn_front, gbn_cmd_fifo, gbn_back.
//
//   Channel  Dir  Signals                            Contents
//   s_axis   in   tvalid tready tdata tuser tlast    ack code, request, final ack
//   m_axis   out  tvalid tready tdata tlast          one result word per request
//   cfg      in   cfg_we_i cfg_idx_i cfg_data_i      window, packets, timeout
//
// One word per cycle sustained while m_axis_tready is high; the back end
// updates all window state for a request in a single step. An accepted word
// enters the queue, then its result is registered. A two-entry queue lets the
// input side run on while the result register waits on m_axis_tready. After
// reset the window is empty and every slot is free; no clearing pass is needed.
module go_back_n_sender_window_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gbn_pkg::TdataInW-1:0]  s_axis_tdata,  // [7:0] ack_code
  input  logic [gbn_pkg::ReqW-1:0]      s_axis_tuser,  // [1:0] req_type
  input  logic                          s_axis_tlast,  // ack_last
  // result words
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [0] sent, [5:1] seq_code, [12:6] packet_index, [13] timed_out,
  // [18:14] rewound, [19] ack_rejected, [20] transfer_done,
  // [25:21] outstanding, [31:26] zero
  output logic [gbn_pkg::TdataOutW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,  // last_packet
  // config writes
  input  logic                          cfg_we_i,
  input  logic [gbn_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [gbn_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gbn_pkg::*;

  cfg_t    cfg_q;
  cmd_t    front_cmd;
  cmd_t    q_cmd;
  logic    q_full;
  logic    q_empty;
  logic    q_pop;
  logic    push;
  result_t res;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_size   <= WindowRst;
      cfg_q.total_packets <= TotalRst;
      cfg_q.timeout_limit <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWindow:  cfg_q.window_size   <= cfg_data_i[SeqW-1:0];
        CfgTotal:   cfg_q.total_packets <= cfg_data_i;
        CfgTimeout: cfg_q.timeout_limit <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;

  gbn_front u_front (
    .req_type_i (s_axis_tuser),
    .ack_code_i (s_axis_tdata),
    .ack_last_i (s_axis_tlast),
    .cmd_o      (front_cmd)
  );

  gbn_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_cmd)
  );

  gbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Pack result word
  assign m_axis_tdata = {6'd0, res.outstanding, res.transfer_done, res.ack_rejected,
                         res.rewound, res.timed_out, res.packet_index, res.seq_code,
                         res.sent};
  assign m_axis_tlast = res.last_packet;

  // A released packet always carries a sequence code in 1..SeqSpace
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[0]) |->
      (m_axis_tdata[5:1] != '0) && (m_axis_tdata[5:1] <= SeqTop))
    else $error("released packet without a valid sequence code");

  // A send and a rewind never come from the same request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[13]))
    else $error("send and timeout reported together");

  // Rewound count is only reported on a timeout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[13]) |-> (m_axis_tdata[18:14] == '0))
    else $error("rewound count without timeout");

  // Outstanding count stays inside the window space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[25:21] <= SeqLast))
    else $error("outstanding count beyond sequence space");

endmodule

/* rtl/gbn_front.sv */
// Front end: decodes an input word into a command for the back end.
// Depends on gbn_pkg.
module gbn_front (
  input  logic [gbn_pkg::ReqW-1:0] req_type_i,
  input  logic [gbn_pkg::AckW-1:0] ack_code_i,
  input  logic                     ack_last_i,
  output gbn_pkg::cmd_t            cmd_o
);
  import gbn_pkg::*;

  logic code_ok;

  // Ack code must lie in 1..SeqSpace
  assign code_ok = (ack_code_i != '0) && (ack_code_i <= AckW'(SeqSpace));

  // Classify request
  always_comb begin
    cmd_o.ack_idx = SeqW'(ack_code_i - 8'd1);
    unique case (req_type_i)
      ReqStart: cmd_o.kind = CmdStart;
      ReqSend:  cmd_o.kind = CmdSend;
      ReqAck: begin
        if (ack_last_i) begin
          cmd_o.kind = CmdDone;
        end else if (!code_ok) begin
          cmd_o.kind = CmdAckBad;
        end else begin
          cmd_o.kind = CmdAckOk;
        end
      end
      ReqPoll:  cmd_o.kind = CmdPoll;
      default:  cmd_o.kind = CmdPoll;
    endcase
  end

endmodule

/* rtl/gbn_cmd_fifo.sv */
// Small command queue between the front end and the back end.
// Depends on gbn_pkg.
module gbn_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbn_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output gbn_pkg::cmd_t cmd_o
);
  import gbn_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FifoCntW'(FifoDepth));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/gbn_back.sv */
// Back end: window state, command execution and the output word register.
// Depends on gbn_pkg.
module gbn_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbn_pkg::cfg_t    cfg_i,
  input  logic             cmd_valid_i,
  input  gbn_pkg::cmd_t    cmd_i,
  output logic             cmd_pop_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output gbn_pkg::result_t res_o
);
  import gbn_pkg::*;

  logic [SeqSpace-1:0] slot_free_q, slot_free_d;
  logic [SeqW-1:0]     next_seq_q, next_seq_d;
  logic [SeqW-1:0]     oldest_q, oldest_d;
  logic [CntW-1:0]     sent_cnt_q, sent_cnt_d;
  logic [CntW-1:0]     idle_q, idle_d;
  logic                done_q, done_d;
  logic                res_valid_q;
  result_t             res_q, res_d;

  logic [SeqW-1:0]     outst;
  logic [SeqW-1:0]     ack_dist;
  logic [SeqW-1:0]     win;
  logic [CntW-1:0]     total;
  logic [CntW:0]       polls;
  logic [SeqSpace-1:0] ack_rng;
  logic [SeqSpace-1:0] rew_rng;
  logic [SeqW-1:0]     off [SeqSpace];

  // Take a command whenever the output register is free or being drained
  assign cmd_pop_o   = cmd_valid_i && (!res_valid_q || res_ready_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign outst    = seq_dist(next_seq_q, oldest_q);
  assign ack_dist = seq_dist(cmd_i.ack_idx, oldest_q);
  assign win      = (cfg_i.window_size > SeqLast) ? SeqLast : cfg_i.window_size;
  assign total    = (cfg_i.total_packets > PktLimit) ? PktLimit : cfg_i.total_packets;
  assign polls    = {1'b0, idle_q} + 9'd1;

  // Per-slot offset from the oldest unacked sequence, for range frees
  always_comb begin
    for (int j = 0; j < SeqSpace; j++) begin
      off[j]     = seq_dist(SeqW'(j), oldest_q);
      ack_rng[j] = (off[j] <= ack_dist);
      rew_rng[j] = (off[j] < outst);
    end
  end

  // Command execution
  always_comb begin
    slot_free_d = slot_free_q;
    next_seq_d  = next_seq_q;
    oldest_d    = oldest_q;
    sent_cnt_d  = sent_cnt_q;
    idle_d      = idle_q;
    done_d      = done_q;
    res_d       = '0;

    if (cmd_i.kind == CmdStart) begin
      slot_free_d = '1;
      next_seq_d  = '0;
      oldest_d    = '0;
      sent_cnt_d  = '0;
      idle_d      = '0;
      done_d      = 1'b0;
    end else if (!done_q) begin
      unique case (cmd_i.kind)
        CmdSend: begin
          if ((outst < win) && slot_free_q[next_seq_q] && (sent_cnt_q < total)) begin
            res_d.sent         = 1'b1;
            res_d.seq_code     = next_seq_q + 5'd1;
            res_d.packet_index = sent_cnt_q[IdxW-1:0];
            res_d.last_packet  = ((sent_cnt_q + 8'd1) == total);
            slot_free_d[next_seq_q] = 1'b0;
            next_seq_d = seq_inc(next_seq_q);
            sent_cnt_d = sent_cnt_q + 8'd1;
          end
        end
        CmdDone: begin
          done_d = 1'b1;
        end
        CmdAckBad: begin
          res_d.ack_rejected = 1'b1;
        end
        CmdAckOk: begin
          idle_d = '0;
          if (ack_dist < outst) begin
            slot_free_d = slot_free_q | ack_rng;
            oldest_d    = seq_inc(cmd_i.ack_idx);
          end
        end
        CmdPoll: begin
          if (polls > {1'b0, cfg_i.timeout_limit}) begin
            slot_free_d     = slot_free_q | rew_rng;
            sent_cnt_d      = (sent_cnt_q >= CntW'(outst)) ? sent_cnt_q - CntW'(outst) : '0;
            next_seq_d      = oldest_q;
            idle_d          = '0;
            res_d.timed_out = 1'b1;
            res_d.rewound   = outst;
          end else begin
            idle_d = polls[CntW-1:0];
          end
        end
        default: begin
        end
      endcase
    end

    res_d.transfer_done = done_d;
    res_d.outstanding   = seq_dist(next_seq_d, oldest_d);
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_free_q <= '1;
      next_seq_q  <= '0;
      oldest_q    <= '0;
      sent_cnt_q  <= '0;
      idle_q      <= '0;
      done_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        slot_free_q <= slot_free_d;
        next_seq_q  <= next_seq_d;
        oldest_q    <= oldest_d;
        sent_cnt_q  <= sent_cnt_d;
        idle_q      <= idle_d;
        done_q      <= done_d;
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule
